/* src/mnas_pkg.sv */
// Shared types, codes and default constants for the MNA element stamper.
// Used by every module under src; depends on nothing.
package mnas_pkg;

    localparam int MAX_NODES_DEF      = 1024;
    localparam int MAX_EXTRA_ROWS_DEF = 256;
    localparam int FRAC_BITS_DEF      = 16;

    localparam int TAG_W = 8;

    localparam logic [1:0] KIND_RES = 2'd0;
    localparam logic [1:0] KIND_CUR = 2'd1;
    localparam logic [1:0] KIND_VSRC = 2'd2;
    localparam logic [1:0] KIND_IND = 2'd3;

    localparam logic [1:0] TGT_MAT = 2'd0;
    localparam logic [1:0] TGT_RHS = 2'd1;
    localparam logic [1:0] TGT_ERR = 2'd2;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic new_epoch;
        logic rd_en;
        logic wr_en;
    } mark_ctl_t;

    typedef struct packed {
        logic busy;
        logic marked;
    } mark_sts_t;

    typedef struct packed {
        logic               emit;
        logic [1:0]         target;
        logic [10:0]        row;
        logic [10:0]        col;
        logic signed [31:0] value;
        logic               last;
    } beat_t;

endpackage

/* src/mna_element_stamper.sv */
// MNA element stamper top level: node count register, sequencer, divider,
// marked-node store and output register. Depends on mnas_pkg, mnas_seq,
// mnas_recip_div and mnas_mark_store. A resistor's first result waits for the
// divider loop, a voltage source or inductor's for the marked-node read and write;
// then one result a cycle while the output is not stalled. One element at a time.
// Reset clears control state and sweeps every entry of the marked-node memory
// with in_ready low; the sweep repeats after every 255th first_element.
module mna_element_stamper
    import mnas_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_EXTRA_ROWS = MAX_EXTRA_ROWS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [10:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               first_element,
    input  logic [1:0]         element_kind,
    input  logic [10:0]        node_plus,
    input  logic [10:0]        node_minus,
    input  logic signed [31:0] element_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         target,
    output logic [10:0]        row_index,
    output logic [10:0]        col_index,
    output logic signed [31:0] entry_value,
    output logic               last_result
);

    localparam int AW = $clog2(MAX_NODES);

    logic [10:0]        node_count_reg;
    mark_ctl_t          mark_ctl;
    mark_sts_t          mark_sts;
    logic [AW-1:0]      mark_addr;
    logic               div_start;
    logic [30:0]        div_divisor;
    logic               div_done;
    logic signed [31:0] div_quot;
    beat_t              beat;
    logic               out_free;
    logic               out_valid_reg, out_valid_next;

    logic [1:0]         target_reg;
    logic [10:0]        row_reg;
    logic [10:0]        col_reg;
    logic signed [31:0] value_reg;
    logic               last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= 11'd1;
        end
        else if (cfg_we)
        begin
            node_count_reg <= cfg_data;
        end
    end

    mnas_seq #(
        .MAX_NODES      (MAX_NODES),
        .MAX_EXTRA_ROWS (MAX_EXTRA_ROWS),
        .FRAC_BITS      (FRAC_BITS)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .node_count    (node_count_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .first_element (first_element),
        .element_kind  (element_kind),
        .node_plus     (node_plus),
        .node_minus    (node_minus),
        .element_value (element_value),
        .mark_ctl      (mark_ctl),
        .mark_addr     (mark_addr),
        .mark_sts      (mark_sts),
        .div_start     (div_start),
        .div_divisor   (div_divisor),
        .div_done      (div_done),
        .div_quot      (div_quot),
        .beat          (beat),
        .out_free      (out_free)
    );

    mnas_recip_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    mnas_mark_store #(
        .MAX_NODES (MAX_NODES)
    ) u_mark (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mark_ctl),
        .addr  (mark_addr),
        .sts   (mark_sts)
    );

    always_comb
    begin
        out_free       = !out_valid_reg || out_ready;
        out_valid_next = out_valid_reg;
        if (beat.emit && out_free)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat.emit && out_free)
        begin
            target_reg <= beat.target;
            row_reg    <= beat.row;
            col_reg    <= beat.col;
            value_reg  <= beat.value;
            last_reg   <= beat.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign target      = target_reg;
    assign row_index   = row_reg;
    assign col_index   = col_reg;
    assign entry_value = value_reg;
    assign last_result = last_reg;

endmodule

/* src/mnas_recip_div.sv */
// Iterative restoring divider producing saturated floor(2^(2*FRAC_BITS) / R).
// One quotient bit per cycle; depends on mnas_pkg.
module mnas_recip_div
    import mnas_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int QW = 2 * FRAC_BITS + 1,
    localparam int QRW = (QW > 32) ? QW : 32,
    localparam int CW = $clog2(QW + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [30:0]        divisor,
    output logic               done,
    output logic signed [31:0] quotient
);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [31:0]   rem_reg;
    logic [QRW-1:0] q_reg;
    logic [30:0]   dvs_reg;

    logic [31:0] rem_sh;
    logic [32:0] trial;
    logic        fits;
    logic [31:0] rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg[30:0], (cnt_reg == CW'(QW))};
        trial    = {1'b0, rem_sh} - {2'b00, dvs_reg};
        fits     = !trial[32];
        rem_next = fits ? trial[31:0] : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[QRW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = (|q_reg[QRW-1:31]) ? SAT_MAX : {1'b0, q_reg[30:0]};

endmodule

/* src/mnas_mark_store.sv */
// Marked-node store: one epoch tag per node in a synchronous memory, plus sweep.
// Depends on mnas_pkg for the tag width and control structs.
module mnas_mark_store
    import mnas_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    localparam int AW = $clog2(MAX_NODES)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  mark_ctl_t     ctl,
    input  logic [AW-1:0] addr,
    output mark_sts_t     sts
);

    logic [TAG_W-1:0] tag_mem [MAX_NODES];
    logic [TAG_W-1:0] rd_data_reg;
    logic [TAG_W-1:0] epoch_reg;
    logic             sweeping_reg;
    logic [AW-1:0]    sweep_addr_reg;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [TAG_W-1:0] mem_wdata;

    always_comb
    begin
        mem_we    = sweeping_reg || ctl.wr_en;
        mem_waddr = sweeping_reg ? sweep_addr_reg : addr;
        mem_wdata = sweeping_reg ? '0 : epoch_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tag_mem[mem_waddr] <= mem_wdata;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= tag_mem[addr];
        end
    end

    // tag zero never matches a live epoch
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweeping_reg   <= 1'b1;
            sweep_addr_reg <= '0;
            epoch_reg      <= TAG_W'(1);
        end
        else if (sweeping_reg)
        begin
            sweep_addr_reg <= sweep_addr_reg + AW'(1);
            if (sweep_addr_reg == AW'(MAX_NODES - 1))
            begin
                sweeping_reg <= 1'b0;
            end
        end
        else if (ctl.new_epoch)
        begin
            if (epoch_reg == '1)
            begin
                epoch_reg      <= TAG_W'(1);
                sweeping_reg   <= 1'b1;
                sweep_addr_reg <= '0;
            end
            else
            begin
                epoch_reg <= epoch_reg + TAG_W'(1);
            end
        end
    end

    assign sts.busy   = sweeping_reg;
    assign sts.marked = (rd_data_reg == epoch_reg);

endmodule

/* src/mnas_seq.sv */
// Per-element sequencer: checks, divider control, marked-node read/modify/write
// and result beat generation. Depends on mnas_pkg.
module mnas_seq
    import mnas_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_EXTRA_ROWS = MAX_EXTRA_ROWS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int AW = $clog2(MAX_NODES),
    localparam int ERW = $clog2(MAX_EXTRA_ROWS + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [10:0]        node_count,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               first_element,
    input  logic [1:0]         element_kind,
    input  logic [10:0]        node_plus,
    input  logic [10:0]        node_minus,
    input  logic signed [31:0] element_value,
    output mark_ctl_t          mark_ctl,
    output logic [AW-1:0]      mark_addr,
    input  mark_sts_t          mark_sts,
    output logic               div_start,
    output logic [30:0]        div_divisor,
    input  logic               div_done,
    input  logic signed [31:0] div_quot,
    output beat_t              beat,
    input  logic               out_free
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_RDP   = 3'd3;
    localparam logic [2:0] S_RDM   = 3'd4;
    localparam logic [2:0] S_LATM  = 3'd5;
    localparam logic [2:0] S_WRM   = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    localparam logic signed [31:0] ONE     = 32'(64'd1 << FRAC_BITS);
    localparam logic signed [31:0] NEG_ONE = -ONE;

    logic [2:0]         state_reg, state_next;
    logic [1:0]         kind_reg, kind_next;
    logic [10:0]        np_reg, np_next;
    logic [10:0]        nm_reg, nm_next;
    logic signed [31:0] val_reg, val_next;
    logic [ERW-1:0]     xrc_reg, xrc_next;
    logic [10:0]        row_reg, row_next;
    logic               err_reg, err_next;
    logic [4:0]         mask_reg, mask_next;
    logic               pnew_reg, pnew_next;

    logic [10:0]        nodes;
    logic [10:0]        p1, m1;
    logic [4:0]         low;
    logic [4:0]         rest;
    logic               mnew;
    logic signed [31:0] neg_val;
    logic signed [31:0] neg_g;

    function automatic logic [AW-1:0] node_addr(input logic [10:0] n);
        logic [10:0] n1;
        n1 = n - 11'd1;
        return (n == 11'd0) ? '0 : AW'(n1);
    endfunction

    always_comb
    begin
        nodes   = (32'(node_count) > MAX_NODES) ? 11'(MAX_NODES) : node_count;
        p1      = np_reg - 11'd1;
        m1      = nm_reg - 11'd1;
        low     = mask_reg & (~mask_reg + 5'd1);
        rest    = mask_reg & ~low;
        neg_val = (val_reg == SAT_MIN) ? SAT_MAX : -val_reg;
        neg_g   = -div_quot;
        mnew    = (nm_reg != 11'd0) && !mark_sts.marked &&
                  !((nm_reg == np_reg) && pnew_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        np_next    = np_reg;
        nm_next    = nm_reg;
        val_next   = val_reg;
        xrc_next   = xrc_reg;
        row_next   = row_reg;
        err_next   = err_reg;
        mask_next  = mask_reg;
        pnew_next  = pnew_reg;

        in_ready   = 1'b0;
        mark_ctl   = '0;
        mark_addr  = node_addr(np_reg);
        div_start  = 1'b0;
        beat       = '0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = !mark_sts.busy;
                if (in_valid && !mark_sts.busy)
                begin
                    kind_next = element_kind;
                    np_next   = node_plus;
                    nm_next   = node_minus;
                    val_next  = element_value;
                    err_next  = 1'b0;
                    mask_next = '0;
                    if (first_element)
                    begin
                        xrc_next           = '0;
                        mark_ctl.new_epoch = 1'b1;
                    end
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!mark_sts.busy)
                begin
                    if ((np_reg > nodes) || (nm_reg > nodes))
                    begin
                        err_next   = 1'b1;
                        mask_next  = 5'b00001;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        case (kind_reg)
                            KIND_RES:
                            begin
                                if (val_reg[31] || (val_reg == '0))
                                begin
                                    err_next   = 1'b1;
                                    mask_next  = 5'b00001;
                                    state_next = S_EMIT;
                                end
                                else if ((np_reg == 11'd0) && (nm_reg == 11'd0))
                                begin
                                    state_next = S_IDLE;
                                end
                                else
                                begin
                                    div_start  = 1'b1;
                                    state_next = S_DIV;
                                    if (np_reg == 11'd0)
                                        mask_next = 5'b01000;
                                    else if (nm_reg == 11'd0)
                                        mask_next = 5'b00001;
                                    else
                                        mask_next = 5'b01111;
                                end
                            end
                            KIND_CUR:
                            begin
                                mask_next  = {3'b000, nm_reg != 11'd0, np_reg != 11'd0};
                                state_next = S_EMIT;
                            end
                            default:
                            begin
                                if (xrc_reg == ERW'(MAX_EXTRA_ROWS))
                                begin
                                    err_next   = 1'b1;
                                    mask_next  = 5'b00001;
                                    state_next = S_EMIT;
                                end
                                else
                                begin
                                    row_next   = 11'(32'(nodes) + 32'(xrc_reg));
                                    xrc_next   = xrc_reg + ERW'(1);
                                    state_next = S_RDP;
                                end
                            end
                        endcase
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_RDP:
            begin
                mark_ctl.rd_en = 1'b1;
                mark_addr      = node_addr(np_reg);
                state_next     = S_RDM;
            end
            S_RDM:
            begin
                mark_ctl.rd_en = 1'b1;
                mark_addr      = node_addr(nm_reg);
                pnew_next      = (np_reg != 11'd0) && !mark_sts.marked;
                state_next     = S_LATM;
            end
            S_LATM:
            begin
                mark_ctl.wr_en = pnew_reg;
                mark_addr      = node_addr(np_reg);
                mask_next      = {mnew, mnew, pnew_reg, pnew_reg, kind_reg == KIND_VSRC};
                state_next     = S_WRM;
            end
            S_WRM:
            begin
                mark_ctl.wr_en = mask_reg[3];
                mark_addr      = node_addr(nm_reg);
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                if (mask_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    beat.emit = 1'b1;
                    beat.last = (rest == '0);
                    if (err_reg)
                    begin
                        beat.target = TGT_ERR;
                    end
                    else
                    begin
                        case (kind_reg)
                            KIND_RES:
                            begin
                                beat.target = TGT_MAT;
                                if (low[0])
                                begin
                                    beat.row = p1; beat.col = p1; beat.value = div_quot;
                                end
                                else if (low[1])
                                begin
                                    beat.row = p1; beat.col = m1; beat.value = neg_g;
                                end
                                else if (low[2])
                                begin
                                    beat.row = m1; beat.col = p1; beat.value = neg_g;
                                end
                                else
                                begin
                                    beat.row = m1; beat.col = m1; beat.value = div_quot;
                                end
                            end
                            KIND_CUR:
                            begin
                                beat.target = TGT_RHS;
                                if (low[0])
                                begin
                                    beat.row = p1; beat.value = neg_val;
                                end
                                else
                                begin
                                    beat.row = m1; beat.value = val_reg;
                                end
                            end
                            default:
                            begin
                                beat.target = TGT_MAT;
                                if (low[0])
                                begin
                                    beat.target = TGT_RHS;
                                    beat.row = row_reg; beat.value = val_reg;
                                end
                                else if (low[1])
                                begin
                                    beat.row = row_reg; beat.col = p1; beat.value = ONE;
                                end
                                else if (low[2])
                                begin
                                    beat.row = p1; beat.col = row_reg; beat.value = ONE;
                                end
                                else if (low[3])
                                begin
                                    beat.row = row_reg; beat.col = m1; beat.value = NEG_ONE;
                                end
                                else
                                begin
                                    beat.row = m1; beat.col = row_reg; beat.value = NEG_ONE;
                                end
                            end
                        endcase
                    end
                    if (out_free)
                    begin
                        mask_next = rest;
                        if (rest == '0)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign div_divisor = val_reg[30:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            xrc_reg   <= '0;
            err_reg   <= 1'b0;
            mask_reg  <= '0;
            pnew_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            xrc_reg   <= xrc_next;
            err_reg   <= err_next;
            mask_reg  <= mask_next;
            pnew_reg  <= pnew_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        np_reg   <= np_next;
        nm_reg   <= nm_next;
        val_reg  <= val_next;
        row_reg  <= row_next;
    end

endmodule

/* src/mnas_checker.sv */
// Port-level checker for mna_element_stamper, attached by the bind below.
// Depends on mnas_pkg for the target codes.
module mnas_checker
    import mnas_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         target,
    input logic [10:0]        row_index,
    input logic [10:0]        col_index,
    input logic signed [31:0] entry_value,
    input logic               last_result
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid &&
        $stable({target, row_index, col_index, entry_value, last_result}))
        else $error("result changed while stalled");

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (target == TGT_ERR) |-> last_result && (row_index == 11'd0) &&
        (col_index == 11'd0) && (entry_value == 32'sd0))
        else $error("malformed error result");

    a_rhs_col: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (target == TGT_RHS) |-> (col_index == 11'd0))
        else $error("rhs delta with nonzero column");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("transaction taken while previous element in work");

endmodule

bind mna_element_stamper mnas_checker u_mnas_checker (.*);

/* verif/mna_element_stamper_tb.sv */
// Testbench for mna_element_stamper: directed stimulus table, an extra-row run,
// then random netlists. Each result is checked against the table's expected
// stamp or the in-bench predictor. Depends on mnas_pkg and mna_element_stamper RTL.
module mna_element_stamper_tb
    import mnas_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 20;
    localparam int SETTLE       = 2 * FRAC_BITS_DEF + 16;
    localparam int LONG_HOLD    = 400;
    localparam int RUN_LIMIT_NS = 10_000_000;
    localparam int PHASE_ITEMS  = 50;

    typedef struct packed {
        logic               first;
        logic [1:0]         kind;
        logic [10:0]        node_plus;
        logic [10:0]        node_minus;
        logic signed [31:0] value;
    } element_t;

    typedef struct packed {
        logic [1:0]         tgt;
        logic [10:0]        row;
        logic [10:0]        col;
        logic signed [31:0] val;
        logic               last;
    } stamp_t;

    typedef struct {
        bit          is_cfg;
        logic [10:0] cfg;
        element_t    el;
        bit          typed;
        stamp_t      want;
    } script_step_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [10:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               first_element = 1'b0;
    logic [1:0]         element_kind = KIND_RES;
    logic [10:0]        node_plus = '0;
    logic [10:0]        node_minus = '0;
    logic signed [31:0] element_value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         target;
    logic [10:0]        row_index;
    logic [10:0]        col_index;
    logic signed [31:0] entry_value;
    logic               last_result;

    logic [MAX_NODES_DEF-1:0] node_seen = '0;
    int unsigned              extra_rows = 0;
    int unsigned              node_count_model = 1;
    stamp_t                   new_stamps[$];
    stamp_t                   pending_stamps[$];
    script_step_t             script[$];
    int unsigned              mismatch_count = 0;
    int unsigned              send_idle_pct = 0;
    int unsigned              recv_stall_pct = 0;
    logic                     holding = 1'b0;
    event                     hold_start;

    mna_element_stamper i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .first_element (first_element),
        .element_kind  (element_kind),
        .node_plus     (node_plus),
        .node_minus    (node_minus),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .target        (target),
        .row_index     (row_index),
        .col_index     (col_index),
        .entry_value   (entry_value),
        .last_result   (last_result)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAIL mna_element_stamper");
        $finish;
    end

    task automatic log_error(input string msg);
        mismatch_count++;
        $display("ERROR %0t: %s", $time, msg);
    endtask

    function automatic int unsigned live_nodes();
        return node_count_model > MAX_NODES_DEF ? MAX_NODES_DEF : node_count_model;
    endfunction

    function automatic void add_stamp(input logic [1:0] tgt, input int unsigned row,
                                      input int unsigned col, input longint val);
        stamp_t s;
        s.tgt  = tgt;
        s.row  = 11'(row);
        s.col  = 11'(col);
        if (val > longint'(SAT_MAX))
            s.val = SAT_MAX;
        else if (val < longint'(SAT_MIN))
            s.val = SAT_MIN;
        else
            s.val = 32'(val);
        s.last = 1'b0;
        new_stamps.push_back(s);
    endfunction

    function automatic void add_incidence(input int unsigned node, input int unsigned row,
                                          input longint one);
        if (node == 0 || node_seen[node-1])
            return;
        add_stamp(TGT_MAT, row, node - 1, one);
        add_stamp(TGT_MAT, node - 1, row, one);
        node_seen[node-1] = 1'b1;
    endfunction

    function automatic void predict_stamps(input element_t e);
        int unsigned np;
        int unsigned nm;
        int unsigned row;
        longint      v;
        longint      g;
        longint      one;
        stamp_t      s;
        np  = e.node_plus;
        nm  = e.node_minus;
        v   = longint'($signed(e.value));
        one = longint'(1) << FRAC_BITS_DEF;
        new_stamps.delete();
        if (e.first)
        begin
            node_seen  = '0;
            extra_rows = 0;
        end
        if (np > live_nodes() || nm > live_nodes())
            add_stamp(TGT_ERR, 0, 0, 0);
        else if (e.kind == KIND_RES)
        begin
            if (v <= 0)
                add_stamp(TGT_ERR, 0, 0, 0);
            else
            begin
                g = (longint'(1) << (2 * FRAC_BITS_DEF)) / v;
                if (g > longint'(SAT_MAX))
                    g = longint'(SAT_MAX);
                if (np == 0 && nm != 0)
                    add_stamp(TGT_MAT, nm - 1, nm - 1, g);
                else if (np != 0 && nm == 0)
                    add_stamp(TGT_MAT, np - 1, np - 1, g);
                else if (np != 0)
                begin
                    add_stamp(TGT_MAT, np - 1, np - 1, g);
                    add_stamp(TGT_MAT, np - 1, nm - 1, -g);
                    add_stamp(TGT_MAT, nm - 1, np - 1, -g);
                    add_stamp(TGT_MAT, nm - 1, nm - 1, g);
                end
            end
        end
        else if (e.kind == KIND_CUR)
        begin
            if (np != 0)
                add_stamp(TGT_RHS, np - 1, 0, -v);
            if (nm != 0)
                add_stamp(TGT_RHS, nm - 1, 0, v);
        end
        else if (extra_rows >= MAX_EXTRA_ROWS_DEF)
            add_stamp(TGT_ERR, 0, 0, 0);
        else
        begin
            row = live_nodes() + extra_rows;
            extra_rows++;
            if (e.kind == KIND_VSRC)
                add_stamp(TGT_RHS, row, 0, v);
            add_incidence(np, row, one);
            add_incidence(nm, row, -one);
        end
        if (new_stamps.size() > 0)
        begin
            s = new_stamps[new_stamps.size()-1];
            s.last = 1'b1;
            new_stamps[new_stamps.size()-1] = s;
        end
    endfunction

    function automatic logic [10:0] random_node(input int unsigned nodes);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return '0;
        else if (pick < 94)
            return 11'($urandom_range(1, nodes));
        else
            return 11'($urandom_range(0, 2047));
    endfunction

    function automatic element_t random_element(input bit first);
        element_t    e;
        int unsigned pick;
        e.first      = first || ($urandom_range(0, 9) == 0);
        e.kind       = 2'($urandom_range(0, 3));
        e.node_plus  = random_node(live_nodes());
        e.node_minus = random_node(live_nodes());
        pick         = $urandom_range(0, 99);
        if (e.kind == KIND_RES)
        begin
            if (pick < 3)
                e.value = '0;
            else if (pick < 8)
                e.value = {1'b1, 31'($urandom())};
            else if (pick < 18)
                e.value = 32'($urandom_range(1, 3));
            else if (pick < 55)
                e.value = 32'($urandom_range(1 << 12, 1 << 22));
            else
                e.value = {1'b0, 31'($urandom())};
        end
        else if (pick < 10)
            e.value = pick[0] ? SAT_MAX : SAT_MIN;
        else if (pick < 40)
            e.value = $urandom_range(0, 1 << 18) - (1 << 17);
        else
            e.value = $urandom();
        return e;
    endfunction

    function automatic void add_step(input bit first, input logic [1:0] kind,
                                     input int unsigned np, input int unsigned nm,
                                     input logic [31:0] val, input bit typed = 1'b0,
                                     input logic [1:0] tgt = TGT_MAT,
                                     input int unsigned row = 0, input int unsigned col = 0,
                                     input logic [31:0] ev = '0);
        script_step_t st;
        st.is_cfg        = 1'b0;
        st.cfg           = '0;
        st.el.first      = first;
        st.el.kind       = kind;
        st.el.node_plus  = 11'(np);
        st.el.node_minus = 11'(nm);
        st.el.value      = val;
        st.typed         = typed;
        st.want.tgt      = tgt;
        st.want.row      = 11'(row);
        st.want.col      = 11'(col);
        st.want.val      = ev;
        st.want.last     = 1'b1;
        script.push_back(st);
    endfunction

    function automatic void add_cfg(input logic [10:0] value);
        script_step_t st;
        st.is_cfg = 1'b1;
        st.cfg    = value;
        st.el     = '0;
        st.typed  = 1'b0;
        st.want   = '0;
        script.push_back(st);
    endfunction

    task automatic send_element(input element_t e, input bit typed = 1'b0,
                                input stamp_t want = '0);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        first_element <= e.first;
        element_kind  <= e.kind;
        node_plus     <= e.node_plus;
        node_minus    <= e.node_minus;
        element_value <= e.value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_stamps(e);
        if (typed)
            pending_stamps.push_back(want);
        else
            foreach (new_stamps[i])
                pending_stamps.push_back(new_stamps[i]);
    endtask

    task automatic wait_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_stamps.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic load_node_count(input logic [10:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        node_count_model = value;
    endtask

    always @(negedge clk)
        out_ready <= !holding && ($urandom_range(0, 99) >= recv_stall_pct);

    initial
    forever
    begin
        @(hold_start);
        holding = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        holding = 1'b0;
    end

    always @(posedge clk)
    begin
        stamp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_stamps.size() == 0)
                log_error("result transaction with nothing pending");
            else
            begin
                want = pending_stamps.pop_front();
                if (target !== want.tgt)
                    log_error($sformatf("target %0d, want %0d", target, want.tgt));
                if (row_index !== want.row)
                    log_error($sformatf("row_index %0d, want %0d", row_index, want.row));
                if (col_index !== want.col)
                    log_error($sformatf("col_index %0d, want %0d", col_index, want.col));
                if (entry_value !== want.val)
                    log_error($sformatf("entry_value %0d, want %0d", entry_value, want.val));
                if (last_result !== want.last)
                    log_error($sformatf("last_result %0b, want %0b", last_result, want.last));
            end
        end
    end

    initial
    begin
        element_t e;

        add_step(1, KIND_RES, 1, 0, 32'h0001_0000, 1, TGT_MAT, 0, 0, 32'h0001_0000);
        add_step(0, KIND_RES, 2, 0, 32'h0001_0000, 1, TGT_ERR, 0, 0, 32'h0);
        add_step(0, KIND_VSRC, 1, 0, 32'h0002_0000);
        add_cfg(11'd1024);
        add_step(1, KIND_RES, 1024, 1, 32'h0000_0001);
        add_step(0, KIND_RES, 0, 1024, 32'h7FFF_FFFF, 1, TGT_MAT, 1023, 1023, 32'h2);
        add_step(0, KIND_RES, 5, 0, 32'h0000_0002, 1, TGT_MAT, 4, 4, 32'h7FFF_FFFF);
        add_step(0, KIND_RES, 3, 0, 32'h0000_0000, 1, TGT_ERR, 0, 0, 32'h0);
        add_step(0, KIND_RES, 3, 5, 32'h8000_0000, 1, TGT_ERR, 0, 0, 32'h0);
        add_step(0, KIND_RES, 0, 0, 32'h0001_0000);
        add_step(0, KIND_RES, 8, 8, 32'h0000_0003);
        add_step(1, KIND_RES, 1025, 0, 32'h0001_0000, 1, TGT_ERR, 0, 0, 32'h0);
        add_step(0, KIND_CUR, 2047, 2047, 32'h0001_0000, 1, TGT_ERR, 0, 0, 32'h0);
        add_step(0, KIND_CUR, 9, 0, 32'h8000_0000, 1, TGT_RHS, 8, 0, 32'h7FFF_FFFF);
        add_step(0, KIND_CUR, 0, 9, 32'hFFFF_FFFB, 1, TGT_RHS, 8, 0, 32'hFFFF_FFFB);
        add_step(0, KIND_CUR, 4, 7, 32'h7FFF_FFFF);
        add_step(0, KIND_CUR, 1024, 1024, 32'h8000_0000);
        add_step(1, KIND_VSRC, 1, 2, 32'h7FFF_FFFF);
        add_step(0, KIND_VSRC, 2, 3, 32'hFFFF_0000);
        add_step(0, KIND_IND, 1, 2, 32'hDEAD_BEEF);
        add_step(0, KIND_IND, 0, 0, 32'h0);
        add_step(0, KIND_IND, 5, 5, 32'h0);
        add_step(0, KIND_VSRC, 6, 6, 32'h0);
        add_step(0, KIND_VSRC, 0, 1025, 32'h1, 1, TGT_ERR, 0, 0, 32'h0);
        add_cfg(11'd2047);
        add_step(1, KIND_VSRC, 1024, 0, 32'h8000_0000);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                wait_quiet();
                load_node_count(script[i].cfg);
            end
            else
                send_element(script[i].el, script[i].typed, script[i].want);
        end

        // use up every extra row, then run past the end of them
        wait_quiet();
        load_node_count(11'd6);
        for (int n = 0; n < MAX_EXTRA_ROWS_DEF + 4; n++)
        begin
            e.first = (n == 0) || (n == MAX_EXTRA_ROWS_DEF + 3);
            e.kind  = ($urandom_range(0, 3) == 0) ? KIND_VSRC : KIND_IND;
            if ($urandom_range(0, 4) == 0)
            begin
                e.node_plus  = 11'($urandom_range(0, 6));
                e.node_minus = 11'($urandom_range(0, 6));
            end
            else
            begin
                e.node_plus  = '0;
                e.node_minus = '0;
            end
            e.value = $urandom();
            send_element(e);
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            wait_quiet();
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    load_node_count(11'd1024);
                    -> hold_start;
                end
                1:
                begin
                    send_idle_pct  = 71;
                    recv_stall_pct = 0;
                    load_node_count(11'($urandom_range(2, 12)));
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 71;
                    load_node_count(11'd2047);
                end
                default:
                begin
                    send_idle_pct  = 38;
                    recv_stall_pct = 38;
                    load_node_count(11'($urandom_range(1, 1024)));
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_element(random_element(n == 0));
        end

        wait_quiet();
        if (mismatch_count == 0)
            $display("PASS mna_element_stamper");
        else
            $display("FAIL mna_element_stamper");
        $finish;
    end

endmodule
